>>> hdl/ctd_pkg.sv
// Shared types, constants and a helper function for the chunked transfer decoder.
package ctd_pkg;

  // Default width of the chunk size and byte counters.
  localparam int SIZE_BITS_DEF = 32;

  // Byte and field widths.
  localparam int BYTE_W    = 8;
  localparam int LINE_W    = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 8;
  localparam int STATUS_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EVEN_CHECK   = 4'd1;

  // Configuration reset values.
  localparam logic [LINE_W-1:0] HEADER_LIMIT_RST = 8'd100;
  localparam logic              EVEN_CHECK_RST   = 1'b1;

  // Line terminator characters.
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  // Sticky decoder status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_BUSY  = 3'd0,
    ST_DONE  = 3'd1,
    ST_ODD   = 3'd2,
    ST_LONG  = 3'd3,
    ST_TERM  = 3'd4,
    ST_AFTER = 3'd5
  } ctd_status_t;

  // Configuration register contents.
  typedef struct packed {
    logic [LINE_W-1:0] header_limit;
    logic              even_check;
  } ctd_cfg_t;

  // One registered input byte on its way to the decoder.
  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
  } ctd_item_t;

  // One decoded result.
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic              chunk_last;
    ctd_status_t       status;
  } ctd_result_t;

  // Hex digit decode result.
  typedef struct packed {
    logic       is_hex;
    logic [3:0] nib;
  } ctd_hex_t;

  // Decodes one ASCII hex digit, either case.
  function automatic ctd_hex_t hex_decode(input logic [BYTE_W-1:0] c);
    ctd_hex_t h;
    logic [BYTE_W-1:0] d;
    h.is_hex = 1'b0;
    h.nib    = 4'd0;
    d        = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d        = c - 8'h30;
      h.is_hex = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d        = c - 8'h57;
      h.is_hex = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d        = c - 8'h37;
      h.is_hex = 1'b1;
    end
    h.nib = d[3:0];
    return h;
  endfunction

endpackage

>>> hdl/ctd_cfg_regs.sv
// Configuration register bank of the chunked transfer decoder.
module ctd_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ctd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctd_pkg::CFG_DAT_W-1:0]      cfg_data,
  output ctd_pkg::ctd_cfg_t                  cfg
);
  import ctd_pkg::*;

  logic [LINE_W-1:0] header_limit_r;
  logic              even_check_r;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_limit_r <= HEADER_LIMIT_RST;
      even_check_r   <= EVEN_CHECK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER_LIMIT: header_limit_r <= cfg_data[LINE_W-1:0];
        REG_EVEN_CHECK:   even_check_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.header_limit = header_limit_r;
  assign cfg.even_check   = even_check_r;

endmodule

>>> hdl/ctd_in_stage.sv
// Input register stage of the chunked transfer decoder.
module ctd_in_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ctd_pkg::BYTE_W-1:0]     in_tdata,
  input  logic                           take,
  output ctd_pkg::ctd_item_t             item
);
  import ctd_pkg::*;

  logic              vld_r;
  logic [BYTE_W-1:0] data_r;

  // Space is free when the stage is empty or its byte leaves this cycle.
  assign in_tready = !vld_r || take;

  // Valid flag of the held byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  // Payload capture on each transfer.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

  assign item.vld  = vld_r;
  assign item.data = data_r;

endmodule

>>> hdl/ctd_core.sv
// Decoder state, per-byte update logic and result register.
module ctd_core #(
  parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctd_pkg::ctd_cfg_t      cfg,
  input  ctd_pkg::ctd_item_t     item,
  output logic                   take,
  output logic                   res_valid,
  input  logic                   res_ready,
  output ctd_pkg::ctd_result_t   res
);
  import ctd_pkg::*;

  typedef enum logic [2:0] {
    PH_LINE = 3'd0,
    PH_DATA = 3'd1,
    PH_CRLF = 3'd2,
    PH_END  = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]  chunk_size_r, chunk_size_nxt;
  logic [SIZE_BITS-1:0]  bytes_done_r, bytes_done_nxt;
  logic [LINE_W-1:0]     line_count_r, line_count_nxt;
  logic                  digits_stopped_r, digits_stopped_nxt;
  logic                  saw_cr_r, saw_cr_nxt;
  ctd_status_t           sticky_r, sticky_nxt;

  logic                  out_v_r, out_v_nxt;
  ctd_result_t           res_r, res_nxt;

  logic [BYTE_W-1:0]     c;
  ctd_hex_t              hx;
  logic [SIZE_BITS-1:0]  bytes_inc;
  logic [SIZE_BITS-1:0]  size_dig;
  logic                  size_sat;
  logic [LINE_W-1:0]     lc_after_cr;
  logic [LINE_W-1:0]     lc_b;
  logic                  ds_b;
  logic                  cr_long;
  logic                  pv;
  logic                  pl;

  // A byte moves on when the result register is free or being emptied.
  assign take = item.vld && (!out_v_r || res_ready);

  // Shared terms of the byte update.
  assign c           = item.data;
  assign hx          = hex_decode(c);
  assign bytes_inc   = bytes_done_r + {{(SIZE_BITS-1){1'b0}}, 1'b1};
  assign size_sat    = |chunk_size_r[SIZE_BITS-1:SIZE_BITS-4];
  assign size_dig    = size_sat ? {SIZE_BITS{1'b1}} : {chunk_size_r[SIZE_BITS-5:0], hx.nib};
  assign lc_after_cr = line_count_r + 8'd1;
  assign cr_long     = line_count_r >= cfg.header_limit;
  // A held CR that turns out not to start CR LF is counted as a line byte first.
  assign lc_b        = saw_cr_r ? lc_after_cr : line_count_r;
  assign ds_b        = saw_cr_r ? 1'b1 : digits_stopped_r;

  // Next state for the byte being taken.
  always_comb begin
    phase_nxt          = phase_r;
    chunk_size_nxt     = chunk_size_r;
    bytes_done_nxt     = bytes_done_r;
    line_count_nxt     = line_count_r;
    digits_stopped_nxt = digits_stopped_r;
    saw_cr_nxt         = saw_cr_r;
    sticky_nxt         = sticky_r;
    pv                 = 1'b0;
    pl                 = 1'b0;
    if (take) begin
      if (sticky_r == ST_BUSY) begin
        unique case (phase_r)
          PH_LINE: begin
            if (saw_cr_r && c == CH_LF) begin
              // End of the size line.
              if (cfg.even_check && line_count_r[0]) begin
                sticky_nxt = ST_ODD;
              end else begin
                saw_cr_nxt = 1'b0;
                if (chunk_size_r == '0) begin
                  phase_nxt = PH_END;
                end else begin
                  phase_nxt      = PH_DATA;
                  bytes_done_nxt = '0;
                end
              end
            end else if (saw_cr_r && cr_long) begin
              saw_cr_nxt = 1'b0;
              sticky_nxt = ST_LONG;
            end else begin
              if (saw_cr_r) begin
                line_count_nxt     = lc_after_cr;
                digits_stopped_nxt = 1'b1;
                saw_cr_nxt         = 1'b0;
              end
              if (c == CH_CR) begin
                saw_cr_nxt = 1'b1;
              end else if (lc_b >= cfg.header_limit) begin
                sticky_nxt = ST_LONG;
              end else begin
                line_count_nxt     = lc_b + 8'd1;
                digits_stopped_nxt = ds_b || !hx.is_hex;
                if (!ds_b && hx.is_hex) begin
                  chunk_size_nxt = size_dig;
                end
              end
            end
          end
          PH_DATA: begin
            pv             = 1'b1;
            bytes_done_nxt = bytes_inc;
            if (bytes_inc == chunk_size_r) begin
              pl         = 1'b1;
              phase_nxt  = PH_CRLF;
              saw_cr_nxt = 1'b0;
            end
          end
          PH_CRLF, PH_END: begin
            if (!saw_cr_r) begin
              if (c == CH_CR) begin
                saw_cr_nxt = 1'b1;
              end else begin
                sticky_nxt = ST_TERM;
              end
            end else if (c == CH_LF) begin
              if (phase_r == PH_CRLF) begin
                phase_nxt          = PH_LINE;
                chunk_size_nxt     = '0;
                line_count_nxt     = '0;
                digits_stopped_nxt = 1'b0;
                saw_cr_nxt         = 1'b0;
              end else begin
                phase_nxt  = PH_DONE;
                saw_cr_nxt = 1'b0;
                sticky_nxt = ST_DONE;
              end
            end else begin
              sticky_nxt = ST_TERM;
            end
          end
          PH_DONE: begin
            sticky_nxt = ST_AFTER;
          end
          default: begin
            sticky_nxt = ST_AFTER;
          end
        endcase
      end else if (sticky_r == ST_DONE) begin
        sticky_nxt = ST_AFTER;
      end
    end
  end

  // Result register contents.
  always_comb begin
    out_v_nxt = out_v_r;
    res_nxt   = res_r;
    if (take) begin
      out_v_nxt             = 1'b1;
      res_nxt.payload_byte  = pv ? c : '0;
      res_nxt.payload_valid = pv;
      res_nxt.chunk_last    = pl;
      res_nxt.status        = sticky_nxt;
    end else if (res_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Control state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_LINE;
      chunk_size_r     <= '0;
      bytes_done_r     <= '0;
      line_count_r     <= '0;
      digits_stopped_r <= 1'b0;
      saw_cr_r         <= 1'b0;
      sticky_r         <= ST_BUSY;
      out_v_r          <= 1'b0;
      res_r            <= '0;
    end else begin
      phase_r          <= phase_nxt;
      chunk_size_r     <= chunk_size_nxt;
      bytes_done_r     <= bytes_done_nxt;
      line_count_r     <= line_count_nxt;
      digits_stopped_r <= digits_stopped_nxt;
      saw_cr_r         <= saw_cr_nxt;
      sticky_r         <= sticky_nxt;
      out_v_r          <= out_v_nxt;
      res_r            <= res_nxt;
    end
  end

  assign res_valid = out_v_r;
  assign res       = res_r;

`ifndef NO_ASSERTIONS
  // An error status never changes once it is set.
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (sticky_r == ST_ODD || sticky_r == ST_LONG || sticky_r == ST_TERM ||
     sticky_r == ST_AFTER) |=> sticky_r == $past(sticky_r))
    else $error("error status changed");

  // Payload phase is entered only with a nonzero chunk size.
  a_data_size: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> chunk_size_r != '0)
    else $error("payload phase with zero chunk size");

  // Chunk end marks only ever sit on payload results.
  a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.chunk_last) |-> res_r.payload_valid)
    else $error("chunk end mark without payload");

  // Payload is only produced while the decoder is busy.
  a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.payload_valid) |-> res_r.status == ST_BUSY)
    else $error("payload result with final status");
`endif

endmodule

>>> hdl/chunked_transfer_decoder.sv
// Top level of the HTTP/1.1 chunked transfer decoder.
// Takes one body byte per transfer and returns one result per byte, one byte per clock
// sustained while out_tready stays high; each byte passes an input register, then the
// decoder state update and the result register, whose update of the chunk size and byte
// counters sets the rate. The status is sticky until reset. Configuration
// writes are taken at any time but are meant for idle periods; no clearing pass is needed.
module chunked_transfer_decoder #(
  parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] in_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // [7:0] payload_byte, [10:8] status
  output logic                           out_tuser,  // [0] payload_valid
  output logic                           out_tlast,  // chunk_last
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ctd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ctd_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import ctd_pkg::*;

  ctd_cfg_t    cfg;
  ctd_item_t   item;
  ctd_result_t res;
  logic        take;

  ctd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ctd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (take),
    .item      (item)
  );

  ctd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item      (item),
    .take      (take),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result onto the output stream.
  assign out_tdata = {5'd0, res.status, res.payload_byte};
  assign out_tuser = res.payload_valid;
  assign out_tlast = res.chunk_last;

endmodule
